[rtl/cubic_bezier_point_stepper_top_macros.svh]
// Assertion macros shared by the stepper's checker.
`ifndef CUBIC_BEZIER_POINT_STEPPER_TOP_MACROS_SVH
`define CUBIC_BEZIER_POINT_STEPPER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define CBPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define CBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cbps_pkg.sv]
// Shared types, codes and step schedule of the cubic Bezier point stepper.
package cbps_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_POINT   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_HANDLE  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_HANDLE = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_END_POINT     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DIVISIONS     = 3'd4;

    typedef logic [1:0] axis_t;
    typedef logic [3:0] step_t;

    localparam axis_t AXIS_LAST = 2'd2;
    // Nine steps per axis: six interpolations and three plain rotations
    localparam step_t STEP_LAST = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_SUB,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_SHIFT,
        ST_STORE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  take;
        logic  load;
        logic  sub;
        logic  mul_lo;
        logic  mul_hi;
        logic  acc;
        logic  shift;
        logic  store;
        logic  emit;
        axis_t axis;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic idle_tick;
        logic div_busy;
        logic out_free;
    } status_t;

    // Rotation steps drop a used point; all other steps interpolate
    function automatic logic step_is_lerp(input step_t step);
        logic r;
        case (step)
            4'd3, 4'd6, 4'd7: r = 1'b0;
            default:          r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

[rtl/cbps_div.sv]
// Restoring divider for the curve parameter, one quotient bit per cycle.
module cbps_div #(
    parameter int STEP_BITS = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [STEP_BITS-1:0] numer,
    input  logic [STEP_BITS-1:0] denom,
    output logic                 busy,
    output logic [FRAC_BITS-1:0] quo
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [STEP_BITS-1:0] rem_reg;
    logic [STEP_BITS-1:0] den_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;

    logic [STEP_BITS:0]   rem_sh;
    logic [STEP_BITS:0]   rem_step;
    logic                 ge;

    // One restoring step; numer < denom keeps the remainder in STEP_BITS
    assign rem_sh   = {rem_reg, 1'b0};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_step = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;

    // Iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(FRAC_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= numer;
            den_reg <= denom;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_step[STEP_BITS-1:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

[rtl/cbps_dpath.sv]
// Datapath: configuration, step counter, divider, shared lerp multiplier, result register.
module cbps_dpath import cbps_pkg::*; #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 16,
    parameter int STEP_BITS  = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [3*COORD_BITS-1:0] cfg_wdata,
    input  logic                    s_restart,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [COORD_BITS-1:0]   pos_x,
    output logic [COORD_BITS-1:0]   pos_y,
    output logic [COORD_BITS-1:0]   pos_z,
    output logic                    moving,
    output logic                    done_res
);

    localparam int PTW = 3 * COORD_BITS;           // packed control point
    localparam int PW  = COORD_BITS + FRAC_BITS;   // point with fraction
    localparam int DW  = PW + 1;                   // difference of two points
    localparam int UW  = FRAC_BITS + 1;            // parameter, up to 1.0
    localparam int HW  = (DW + 1) / 2;             // low partial product slice
    localparam int GW  = DW - HW;                  // high partial product slice
    localparam int FW  = DW + UW;                  // full product
    localparam int CNW = STEP_BITS + 1;            // step counter

    // Configuration registers
    logic [PTW-1:0]       pt_reg [4];
    logic [STEP_BITS-1:0] div_reg;

    // Curve state
    logic [CNW-1:0] cnt_reg;
    logic           active_reg;

    // Item context captured on accept
    logic restart_reg;
    logic skip_reg;
    logic sat_reg;

    // Interpolation registers
    logic [PW-1:0]         p_reg [4];
    logic [DW-1:0]         d_reg;
    logic [HW+UW-1:0]      plo_reg;
    logic [GW+UW:0]        phi_reg;
    logic [COORD_BITS-1:0] res_reg [3];

    // Result register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_z_reg;
    logic                  moving_reg;
    logic                  done_reg;

    logic [STEP_BITS-1:0] div_eff;
    logic [CNW-1:0]       cnt_eff;
    logic [CNW-1:0]       cnt_inc;
    logic                 sat_start;
    logic                 fin;
    logic                 div_busy;
    logic [FRAC_BITS-1:0] quo;
    logic [UW-1:0]        u_val;
    logic [FW-1:0]        phi_ext;
    logic [FW-1:0]        prod_full;
    logic [FW-1:0]        prod_shr;
    logic [PW-1:0]        lerp_val;
    logic [PW-1:0]        trunc_bias;
    logic [PW-1:0]        trunc_sum;

    // Divisions of zero count as one
    assign div_eff   = (div_reg == '0) ? STEP_BITS'(1) : div_reg;
    assign cnt_eff   = s_restart ? '0 : cnt_reg;
    assign sat_start = cnt_eff >= {1'b0, div_eff};
    assign cnt_inc   = cnt_reg + CNW'(1);
    assign fin       = cnt_inc > {1'b0, div_eff};

    cbps_div #(
        .STEP_BITS (STEP_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.take),
        .numer   (cnt_eff[STEP_BITS-1:0]),
        .denom   (div_eff),
        .busy    (div_busy),
        .quo     (quo)
    );

    // Parameter u: quotient, or exactly 1.0 once the counter reaches divisions
    assign u_val = sat_reg ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quo};

    // Recombine partial products, floor-shift, add to the first point
    assign phi_ext   = {{(HW-1){phi_reg[GW+UW]}}, phi_reg};
    assign prod_full = {phi_ext[FW-HW-1:0], {HW{1'b0}}} + {{GW{1'b0}}, plo_reg};
    assign prod_shr  = $signed(prod_full) >>> FRAC_BITS;
    assign lerp_val  = p_reg[0] + prod_shr[PW-1:0];

    // Truncate toward zero: bias negatives by one less than 1.0
    assign trunc_bias = p_reg[3][PW-1] ? {{COORD_BITS{1'b0}}, {FRAC_BITS{1'b1}}} : '0;
    assign trunc_sum  = p_reg[3] + trunc_bias;

    // Configuration writes, curve state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                pt_reg[k] <= '0;
            end
            div_reg       <= STEP_BITS'(1);
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_START_POINT:   pt_reg[0] <= cfg_wdata;
                    REG_FIRST_HANDLE:  pt_reg[1] <= cfg_wdata;
                    REG_SECOND_HANDLE: pt_reg[2] <= cfg_wdata;
                    REG_END_POINT:     pt_reg[3] <= cfg_wdata;
                    REG_DIVISIONS:     div_reg   <= cfg_wdata[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.take && s_restart) begin
                cnt_reg    <= '0;
                active_reg <= 1'b1;
            end else if (cmd.emit && !skip_reg && !restart_reg) begin
                if (fin) begin
                    cnt_reg    <= '0;
                    active_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_inc;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item context
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            restart_reg <= s_restart;
            skip_reg    <= !s_restart && !active_reg;
            sat_reg     <= sat_start;
        end
    end

    // de Casteljau by rotation: lerp p0,p1 into p3 while the rest shift down
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int k = 0; k < 4; k++) begin
                p_reg[k] <= {pt_reg[k][cmd.axis*COORD_BITS +: COORD_BITS], {FRAC_BITS{1'b0}}};
            end
        end else if (cmd.acc || cmd.shift) begin
            p_reg[0] <= p_reg[1];
            p_reg[1] <= p_reg[2];
            p_reg[2] <= p_reg[3];
            if (cmd.acc) begin
                p_reg[3] <= lerp_val;
            end
        end
        if (cmd.sub) begin
            d_reg <= {p_reg[1][PW-1], p_reg[1]} - {p_reg[0][PW-1], p_reg[0]};
        end
        // Shared multiplier: unsigned low slice, then signed high slice
        if (cmd.mul_lo) begin
            plo_reg <= {{UW{1'b0}}, d_reg[HW-1:0]} * {{HW{1'b0}}, u_val};
        end
        if (cmd.mul_hi) begin
            phi_reg <= $signed({{(UW+1){d_reg[DW-1]}}, d_reg[DW-1:HW]})
                     * $signed({{GW{1'b0}}, 1'b0, u_val});
        end
        if (cmd.store) begin
            res_reg[cmd.axis] <= trunc_sum[PW-1:FRAC_BITS];
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pos_x_reg  <= skip_reg ? '0 : res_reg[0];
            pos_y_reg  <= skip_reg ? '0 : res_reg[1];
            pos_z_reg  <= skip_reg ? '0 : res_reg[2];
            moving_reg <= !skip_reg;
            done_reg   <= !skip_reg && !restart_reg && fin;
        end
    end

    assign status.idle_tick = !s_restart && !active_reg;
    assign status.div_busy  = div_busy;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign pos_x    = pos_x_reg;
    assign pos_y    = pos_y_reg;
    assign pos_z    = pos_z_reg;
    assign moving   = moving_reg;
    assign done_res = done_reg;

endmodule

[rtl/cbps_ctrl.sv]
// Controller: sequences divide, per-axis load, lerp steps, store and emit.
module cbps_ctrl import cbps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;
    step_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.idle_tick ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_LOAD;
                    axis_next  = '0;
                end
            end
            ST_LOAD: begin
                step_next  = '0;
                state_next = step_is_lerp('0) ? ST_SUB : ST_SHIFT;
            end
            ST_SUB:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC, ST_SHIFT: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_STORE;
                end else begin
                    step_next  = step_reg + step_t'(1);
                    state_next = step_is_lerp(step_reg + step_t'(1)) ? ST_SUB : ST_SHIFT;
                end
            end
            ST_STORE: begin
                if (axis_reg == AXIS_LAST) begin
                    state_next = ST_EMIT;
                end else begin
                    axis_next  = axis_reg + axis_t'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.axis = axis_reg;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_LOAD:   cmd.load   = 1'b1;
            ST_SUB:    cmd.sub    = 1'b1;
            ST_MUL_LO: cmd.mul_lo = 1'b1;
            ST_MUL_HI: cmd.mul_hi = 1'b1;
            ST_ACC:    cmd.acc    = 1'b1;
            ST_SHIFT:  cmd.shift  = 1'b1;
            ST_STORE:  cmd.store  = 1'b1;
            ST_EMIT:   cmd.emit   = status.out_free;
            default: ;
        endcase
    end

endmodule

[rtl/cubic_bezier_point_stepper_top.sv]
// A curve item passes through the restoring divider, then each axis in turn on one shared
//   multiplier, then the emit state, before m_tvalid rises.
// A new item is taken only once the last is emitted; an idle tick goes straight to emit.
// A finished result waits in the output register while the next item is taken.
// aresetn is synchronous, active low: idles the curve, divisions to 1, control points to 0.
module cubic_bezier_point_stepper_top import cbps_pkg::*; #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 16,
    parameter int STEP_BITS  = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [3*COORD_BITS-1:0]  cfg_wdata,
    // input items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] restart, rest zero
    // result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,  // pos_x, pos_y, pos_z, zero pad
    output logic [0:0]               m_tuser,   // [0] moving
    output logic                     m_tlast    // done_res
);

    localparam int M_TDATA_BITS = ((3*COORD_BITS+7)/8)*8;

    cmd_t    cmd;
    status_t status;

    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic                  moving;

    cbps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cbps_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .STEP_BITS  (STEP_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_restart (s_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .moving    (moving),
        .done_res  (m_tlast)
    );

    // Pack the point, x lowest
    assign m_tdata = M_TDATA_BITS'({pos_z, pos_y, pos_x});
    assign m_tuser = moving;

endmodule

[rtl/cbps_checker.sv]
// Port-level checker for the stepper, bound to the top level.
`include "cubic_bezier_point_stepper_top_macros.svh"

module cbps_checker #(
    parameter int M_TDATA_BITS = 64
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata,
    input logic [0:0]              m_tuser,
    input logic                    m_tlast
);

    // Items taken in but not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc) begin
            pend_next = pend_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `CBPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
    `CBPS_ASSERT_NOW(a_no_invented, m_tvalid, pend_reg != 2'd0, "result with no item outstanding")
    `CBPS_ASSERT_NOW(a_depth, pend_reg == 2'd2, !s_tready, "input taken with two items outstanding")
    `CBPS_ASSERT_NOW(a_done_moving, m_tvalid && m_tlast, m_tuser[0], "done on a result without a point")
    `CBPS_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tlast, "idle result not zero")

endmodule

bind cubic_bezier_point_stepper_top cbps_checker #(
    .M_TDATA_BITS (M_TDATA_BITS)
) u_cbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
